// File: hw/rtl/sfa_pkg.sv
// Shared types, constants and helpers for the segregated free-list allocator.
// Used by the allocator top level and its testbench; depends on nothing.
`default_nettype none
package sfa_pkg;

	localparam int LIST_COUNT   = 59;
	localparam int ARENA_BYTES  = 4096;
	localparam int HEAP_BYTES   = 65536;
	localparam int HEADER_BYTES = 16;
	localparam int GRAIN        = 8;
	localparam int CLASS_BASE   = 3;

	localparam int GRANULES = HEAP_BYTES / GRAIN;
	localparam int ARENA_G  = ARENA_BYTES / GRAIN;
	localparam int HDR_G    = HEADER_BYTES / GRAIN;
	localparam int MIN_G    = 2 * HDR_G;
	localparam int GRAN_W   = $clog2(GRANULES);
	localparam int ID_W     = GRAN_W + 1;        // top bit marks a list anchor
	localparam int SIZE_W   = GRAN_W + 1;
	localparam int TOP_W    = GRAN_W + 1;
	localparam int TOT_W    = (GRAN_W + 2 > 15) ? GRAN_W + 2 : 15;
	localparam int LIST_W   = $clog2(LIST_COUNT);
	localparam int FIRST_SZ = ARENA_G - 2 * HDR_G;
	localparam int FIRST_CLS = (FIRST_SZ - CLASS_BASE > LIST_COUNT - 1) ?
		LIST_COUNT - 1 : FIRST_SZ - CLASS_BASE;

	typedef enum logic [1:0] {
		TS_NONE  = 2'd0,
		TS_FREE  = 2'd1,
		TS_USED  = 2'd2,
		TS_FENCE = 2'd3
	} tstate_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_ZERO   = 3'd1,
		ST_OOM    = 3'd2,
		ST_DOUBLE = 3'd3,
		ST_NULL   = 3'd4
	} status_t;

	typedef struct packed {
		tstate_t           st;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] left;
		logic [ID_W-1:0]   next;
		logic [ID_W-1:0]   prev;
	} tag_t;

	typedef struct packed {
		logic [ID_W-1:0] next;
		logic [ID_W-1:0] prev;
	} lhead_t;

	typedef logic [4:0] fmask_t;
	localparam fmask_t FM_ST   = 5'b10000;
	localparam fmask_t FM_SIZE = 5'b01000;
	localparam fmask_t FM_LEFT = 5'b00100;
	localparam fmask_t FM_NEXT = 5'b00010;
	localparam fmask_t FM_PREV = 5'b00001;

	typedef struct packed {
		logic        opcode;
		logic [15:0] request_size;
		logic [15:0] block_address;
	} req_t;

	typedef struct packed {
		logic [15:0] data_address;
		logic [2:0]  status;
	} rsp_t;

	localparam logic OP_ALLOC = 1'b0;

	typedef enum logic [5:0] {
		S_CLR, S_IDLE, S_DEC, S_FIN,
		U_RD, U_RMW, U_WR,
		UL_0, UL_1, UL_2,
		PS_0, PS_1, PS_2, PS_3,
		A_SCAN, A_LCHK, A_WSTART, A_WCHK, A_GOT, A_S1, A_S2, A_N1,
		G_0, G_1, G_2, G_F1, G_F2, G_F3, G_F4, G_E1, G_E2, G_END,
		F_1, F_2, F_3, F_4, F_R1, F_R2, F_R3, F_R4, F_L2, F_L3,
		F_B1, F_B2, F_B3, F_B4, RL_CHK, RL_PUSH
	} fsm_t;

	function automatic logic [LIST_W-1:0] cls(input logic [TOT_W-1:0] s);
		logic [TOT_W-1:0] i;
		begin
			i = (s >= TOT_W'(CLASS_BASE)) ? s - TOT_W'(CLASS_BASE) : '0;
			if (i > TOT_W'(LIST_COUNT - 1))
				cls = LIST_W'(LIST_COUNT - 1);
			else
				cls = LIST_W'(i);
		end
	endfunction

	function automatic logic [ID_W-1:0] blk_id(input logic [GRAN_W-1:0] g);
		blk_id = {1'b0, g};
	endfunction

	function automatic logic [ID_W-1:0] lst_id(input logic [LIST_W-1:0] li);
		lst_id = {1'b1, GRAN_W'(li)};
	endfunction

	function automatic tag_t mk_tag(input tstate_t st, input logic [TOT_W-1:0] size,
		input logic [TOT_W-1:0] left, input logic [ID_W-1:0] nx, input logic [ID_W-1:0] pv);
		tag_t t;
		begin
			t.st   = st;
			t.size = SIZE_W'(size);
			t.left = SIZE_W'(left);
			t.next = nx;
			t.prev = pv;
			mk_tag = t;
		end
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module sfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hw/rtl/segregated_free_list_allocator.sv
// Segregated free-list allocator with boundary tags; uses sfa_pkg and sfa_ram.
// Pulse start while busy is low; one result word comes back with done high for one cycle.
//
// After reset the block clears the tag memory, one granule per cycle, with
// busy high. Every request is then worked through a sequencer that does one tag or list
// anchor access per step; a read is an issue step plus the read, and a
// read-modify-write an issue step, a read and a write, so the time per word is set by the
// number of dependent accesses. A free refused on its address ends after decode, one refused
// on its tag after the tag read. An allocate decodes, scans the exact size classes, opens the
// last list and walks its blocks, then takes the block (split, with or without a list move, or
// unlink) and returns the word; each arena grown on the way is set up before the scan
// restarts. The result is presented for one cycle only; the receiver cannot hold it off.
`default_nettype none
module segregated_free_list_allocator
	import sfa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  req_t      req,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	fsm_t state_q, state_d, uret_q, mret_q;

	logic [GRAN_W-1:0] clr_q;
	logic [TOP_W-1:0]  top_q;
	logic [GRAN_W-1:0] lf_q;

	logic [ID_W-1:0] mu_id_q;
	fmask_t          mu_mask_q;
	tag_t            mu_val_q;

	logic [GRAN_W-1:0] m_node_q;
	logic [LIST_W-1:0] m_list_q;
	logic [ID_W-1:0]   ul_n_q, ul_p_q, ps_n_q, wk_q;

	req_t              req_q;
	logic [TOT_W-1:0]  total_q, rest_q, hs_q, ls_q, ns_q, lbsz_q, rl_size_q;
	logic [LIST_W-1:0] l_q, idx_q, rl_old_q;
	logic [GRAN_W-1:0] b_q, a_q, h_q, lg_q, r_q, lb_q, rl_node_q;
	logic              lfree_q;
	logic [15:0]       res_q;
	status_t           status_q;

	// memory ports
	logic              tag_we, tag_re, lst_we, lst_re;
	logic [GRAN_W-1:0] tag_waddr, tag_raddr;
	logic [LIST_W-1:0] lst_waddr, lst_raddr;
	tag_t              tag_wdata, tag_rdata;
	lhead_t            lst_wdata, lst_rdata;

	tag_t rnode, wnode, init_tag;

	sfa_ram #(.WIDTH($bits(tag_t)), .DEPTH(GRANULES)) u_tags (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.re(tag_re), .raddr(tag_raddr), .rdata(tag_rdata)
	);

	sfa_ram #(.WIDTH($bits(lhead_t)), .DEPTH(LIST_COUNT)) u_lists (
		.clk(clk), .we(lst_we), .waddr(lst_waddr), .wdata(lst_wdata),
		.re(lst_re), .raddr(lst_raddr), .rdata(lst_rdata)
	);

	// node view of the last read: anchors have links only
	always_comb begin
		if (mu_id_q[ID_W-1])
			rnode = mk_tag(TS_NONE, '0, '0, lst_rdata.next, lst_rdata.prev);
		else
			rnode = tag_rdata;
		wnode.st   = (mu_mask_q & FM_ST)   != '0 ? mu_val_q.st   : rnode.st;
		wnode.size = (mu_mask_q & FM_SIZE) != '0 ? mu_val_q.size : rnode.size;
		wnode.left = (mu_mask_q & FM_LEFT) != '0 ? mu_val_q.left : rnode.left;
		wnode.next = (mu_mask_q & FM_NEXT) != '0 ? mu_val_q.next : rnode.next;
		wnode.prev = (mu_mask_q & FM_PREV) != '0 ? mu_val_q.prev : rnode.prev;
	end

	// reset image of the first arena
	always_comb begin
		init_tag = '0;
		if (clr_q == '0)
			init_tag = mk_tag(TS_FENCE, TOT_W'(HDR_G), TOT_W'(HDR_G), '0, '0);
		else if (clr_q == GRAN_W'(HDR_G))
			init_tag = mk_tag(TS_FREE, TOT_W'(FIRST_SZ), TOT_W'(HDR_G),
				lst_id(LIST_W'(FIRST_CLS)), lst_id(LIST_W'(FIRST_CLS)));
		else if (clr_q == GRAN_W'(ARENA_G - HDR_G))
			init_tag = mk_tag(TS_FENCE, TOT_W'(HDR_G), TOT_W'(FIRST_SZ), '0, '0);
	end

	// decode helpers
	logic [TOT_W-1:0]  rsize, rleft, tot_calc, split_rest, ns_calc;
	logic [TOT_W-1:0]  top_ext;
	logic [LIST_W-1:0] idx_calc;
	logic              rnext_blk, fits, do_split, grow_ok, is_zero, f_null, f_bad;
	logic              rfree;
	logic [GRAN_W-1:0] nf, h_calc;
	logic [31:0]       h_wide;

	always_comb begin
		rsize     = TOT_W'(rnode.size);
		rleft     = TOT_W'(rnode.left);
		rnext_blk = !rnode.next[ID_W-1];
		tot_calc  = TOT_W'((17'(req_q.request_size) + 17'd7) >> 3) + TOT_W'(HDR_G);
		if (tot_calc < TOT_W'(MIN_G))
			tot_calc = TOT_W'(MIN_G);
		idx_calc  = (tot_calc - TOT_W'(CLASS_BASE) > TOT_W'(LIST_COUNT - 1)) ?
			LIST_W'(LIST_COUNT - 1) : LIST_W'(tot_calc - TOT_W'(CLASS_BASE));
		fits      = rsize >= total_q;
		do_split  = rsize >= total_q + TOT_W'(MIN_G);
		split_rest = rsize - total_q;
		top_ext   = TOT_W'(top_q);
		grow_ok   = top_ext + TOT_W'(ARENA_G) <= TOT_W'(GRANULES);
		nf        = GRAN_W'(top_ext + TOT_W'(ARENA_G - HDR_G));
		is_zero   = req_q.request_size == '0;
		f_null    = req_q.block_address == '0;
		h_wide    = 32'(req_q.block_address[15:3]) - 32'(HDR_G);
		f_bad     = req_q.block_address < 16'(HEADER_BYTES) ||
			req_q.block_address[2:0] != 3'd0 || h_wide >= 32'(top_q);
		h_calc    = GRAN_W'(h_wide);
		rfree     = rnode.st == TS_FREE;
		ns_calc   = (lfree_q ? ls_q : '0) + hs_q + (rfree ? rsize : '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR:    if (clr_q == GRAN_W'(GRANULES - 1)) state_d = S_IDLE;
			S_IDLE:   if (start) state_d = S_DEC;
			S_DEC: begin
				if (req_q.opcode == OP_ALLOC)
					state_d = is_zero ? S_FIN : A_SCAN;
				else
					state_d = (f_null || f_bad) ? S_FIN : U_RD;
			end
			S_FIN:    state_d = S_IDLE;
			U_RD:     state_d = uret_q;
			U_RMW:    state_d = U_WR;
			U_WR:     state_d = uret_q;
			UL_0:     state_d = U_RD;
			UL_1:     state_d = U_RMW;
			UL_2:     state_d = U_RMW;
			PS_0:     state_d = U_RD;
			PS_1, PS_2, PS_3: state_d = U_RMW;
			A_SCAN:   state_d = U_RD;
			A_LCHK:   state_d = rnext_blk ? U_RD : A_SCAN;
			A_WSTART: state_d = rnext_blk ? U_RD : G_0;
			A_WCHK: begin
				if (fits)
					state_d = A_GOT;
				else
					state_d = rnext_blk ? U_RD : G_0;
			end
			A_GOT, A_S1, A_S2: state_d = U_RMW;
			A_N1:     state_d = UL_0;
			G_0:      state_d = grow_ok ? U_RD : S_FIN;
			G_1:      state_d = U_RD;
			G_2:      state_d = rfree ? UL_0 : U_RMW;
			G_F1, G_F2, G_F3, G_E1: state_d = U_RMW;
			G_F4, G_E2: state_d = PS_0;
			G_END:    state_d = A_SCAN;
			F_1:      state_d = (rnode.st == TS_USED) ? U_RMW : S_FIN;
			F_2, F_3: state_d = U_RD;
			F_4: begin
				if (!lfree_q)
					state_d = rfree ? UL_0 : PS_0;
				else
					state_d = rfree ? UL_0 : U_RMW;
			end
			F_R1, F_R2, F_R3, F_L2, F_L3, F_B1, F_B2, F_B3, F_B4: state_d = U_RMW;
			F_R4:     state_d = PS_0;
			RL_CHK:   state_d = (cls(rl_size_q) != rl_old_q) ? UL_0 : S_FIN;
			RL_PUSH:  state_d = PS_0;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs and memory ports
	always_comb begin
		busy      = state_q != S_IDLE;
		done      = state_q == S_FIN;
		rsp.data_address = res_q;
		rsp.status       = status_q;
		tag_we    = 1'b0;
		tag_re    = 1'b0;
		lst_we    = 1'b0;
		lst_re    = 1'b0;
		tag_waddr = mu_id_q[GRAN_W-1:0];
		tag_raddr = mu_id_q[GRAN_W-1:0];
		lst_waddr = mu_id_q[LIST_W-1:0];
		lst_raddr = mu_id_q[LIST_W-1:0];
		tag_wdata = wnode;
		lst_wdata.next = wnode.next;
		lst_wdata.prev = wnode.prev;
		case (state_q)
			S_CLR: begin
				tag_we    = 1'b1;
				tag_waddr = clr_q;
				tag_wdata = init_tag;
				lst_we    = 32'(clr_q) < LIST_COUNT;
				lst_waddr = LIST_W'(clr_q);
				if (clr_q == GRAN_W'(FIRST_CLS)) begin
					lst_wdata.next = blk_id(GRAN_W'(HDR_G));
					lst_wdata.prev = blk_id(GRAN_W'(HDR_G));
				end else begin
					lst_wdata.next = lst_id(LIST_W'(clr_q));
					lst_wdata.prev = lst_id(LIST_W'(clr_q));
				end
			end
			U_RD, U_RMW: begin
				tag_re = !mu_id_q[ID_W-1];
				lst_re = mu_id_q[ID_W-1];
			end
			U_WR: begin
				tag_we = !mu_id_q[ID_W-1];
				lst_we = mu_id_q[ID_W-1];
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			top_q   <= TOP_W'(ARENA_G);
			lf_q    <= GRAN_W'(ARENA_G - HDR_G);
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR)
				clr_q <= clr_q + GRAN_W'(1);
			if (state_q == G_END) begin
				top_q <= top_q + TOP_W'(ARENA_G);
				lf_q  <= nf;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (start) req_q <= req;
			S_DEC: begin
				res_q    <= '0;
				status_q <= ST_OK;
				total_q  <= tot_calc;
				idx_q    <= idx_calc;
				l_q      <= idx_calc;
				h_q      <= h_calc;
				if (req_q.opcode == OP_ALLOC) begin
					if (is_zero) status_q <= ST_ZERO;
				end else if (f_null) begin
					status_q <= ST_NULL;
				end else if (f_bad) begin
					status_q <= ST_DOUBLE;
				end else begin
					mu_id_q <= blk_id(h_calc);
					uret_q  <= F_1;
				end
			end
			UL_0: begin
				mu_id_q <= blk_id(m_node_q);
				uret_q  <= UL_1;
			end
			UL_1: begin
				ul_n_q    <= rnode.next;
				ul_p_q    <= rnode.prev;
				mu_id_q   <= rnode.next;
				mu_mask_q <= FM_PREV;
				mu_val_q  <= mk_tag(TS_NONE, '0, '0, '0, rnode.prev);
				uret_q    <= UL_2;
			end
			UL_2: begin
				mu_id_q   <= ul_p_q;
				mu_mask_q <= FM_NEXT;
				mu_val_q  <= mk_tag(TS_NONE, '0, '0, ul_n_q, '0);
				uret_q    <= mret_q;
			end
			PS_0: begin
				mu_id_q <= lst_id(m_list_q);
				uret_q  <= PS_1;
			end
			PS_1: begin
				ps_n_q    <= rnode.next;
				mu_id_q   <= blk_id(m_node_q);
				mu_mask_q <= FM_NEXT | FM_PREV;
				mu_val_q  <= mk_tag(TS_NONE, '0, '0, rnode.next, lst_id(m_list_q));
				uret_q    <= PS_2;
			end
			PS_2: begin
				mu_id_q   <= ps_n_q;
				mu_mask_q <= FM_PREV;
				mu_val_q  <= mk_tag(TS_NONE, '0, '0, '0, blk_id(m_node_q));
				uret_q    <= PS_3;
			end
			PS_3: begin
				mu_id_q   <= lst_id(m_list_q);
				mu_mask_q <= FM_NEXT;
				mu_val_q  <= mk_tag(TS_NONE, '0, '0, blk_id(m_node_q), '0);
				uret_q    <= mret_q;
			end
			A_SCAN: begin
				if (l_q < LIST_W'(LIST_COUNT - 1)) begin
					mu_id_q <= lst_id(l_q);
					uret_q  <= A_LCHK;
				end else begin
					mu_id_q <= lst_id(LIST_W'(LIST_COUNT - 1));
					uret_q  <= A_WSTART;
				end
			end
			A_LCHK: begin
				if (rnext_blk) begin
					b_q     <= rnode.next[GRAN_W-1:0];
					mu_id_q <= rnode.next;
					uret_q  <= A_GOT;
				end else begin
					l_q <= l_q + LIST_W'(1);
				end
			end
			A_WSTART, A_WCHK: begin
				if (state_q == A_WCHK && fits) begin
					b_q <= wk_q[GRAN_W-1:0];
				end else if (rnext_blk) begin
					wk_q    <= rnode.next;
					mu_id_q <= rnode.next;
					uret_q  <= A_WCHK;
				end
			end
			A_GOT: begin
				rl_old_q <= cls(rsize);
				if (do_split) begin
					rest_q    <= split_rest;
					a_q       <= b_q + GRAN_W'(split_rest);
					res_q     <= 16'({b_q + GRAN_W'(split_rest) + GRAN_W'(HDR_G), 3'b000});
					mu_id_q   <= blk_id(b_q + GRAN_W'(split_rest));
					mu_mask_q <= FM_ST | FM_SIZE | FM_LEFT;
					mu_val_q  <= mk_tag(TS_USED, total_q, split_rest, '0, '0);
					uret_q    <= A_S1;
				end else begin
					res_q     <= 16'({b_q + GRAN_W'(HDR_G), 3'b000});
					mu_id_q   <= blk_id(b_q);
					mu_mask_q <= FM_ST;
					mu_val_q  <= mk_tag(TS_USED, '0, '0, '0, '0);
					uret_q    <= A_N1;
				end
			end
			A_S1: begin
				mu_id_q   <= blk_id(a_q + GRAN_W'(total_q));
				mu_mask_q <= FM_LEFT;
				mu_val_q  <= mk_tag(TS_NONE, '0, total_q, '0, '0);
				uret_q    <= A_S2;
			end
			A_S2: begin
				mu_id_q   <= blk_id(b_q);
				mu_mask_q <= FM_SIZE;
				mu_val_q  <= mk_tag(TS_NONE, rest_q, '0, '0, '0);
				uret_q    <= RL_CHK;
				rl_node_q <= b_q;
				rl_size_q <= rest_q;
			end
			A_N1: begin
				m_node_q <= b_q;
				mret_q   <= S_FIN;
			end
			G_0: begin
				if (grow_ok) begin
					mu_id_q <= blk_id(lf_q);
					uret_q  <= G_1;
				end else begin
					status_q <= ST_OOM;
					res_q    <= '0;
				end
			end
			G_1: begin
				lb_q    <= lf_q - GRAN_W'(rleft);
				mu_id_q <= blk_id(lf_q - GRAN_W'(rleft));
				uret_q  <= G_2;
			end
			G_2: begin
				if (rfree) begin
					lbsz_q   <= rsize;
					m_node_q <= lb_q;
					mret_q   <= G_F1;
				end else begin
					mu_id_q   <= blk_id(lf_q);
					mu_mask_q <= FM_ST | FM_SIZE;
					mu_val_q  <= mk_tag(TS_FREE, TOT_W'(ARENA_G), '0, '0, '0);
					uret_q    <= G_E1;
				end
			end
			G_F1: begin
				ns_q      <= lbsz_q + TOT_W'(ARENA_G);
				mu_id_q   <= blk_id(lb_q);
				mu_mask_q <= FM_SIZE;
				mu_val_q  <= mk_tag(TS_NONE, lbsz_q + TOT_W'(ARENA_G), '0, '0, '0);
				uret_q    <= G_F2;
			end
			G_F2: begin
				mu_id_q   <= blk_id(lf_q);
				mu_mask_q <= FM_ST;
				mu_val_q  <= mk_tag(TS_NONE, '0, '0, '0, '0);
				uret_q    <= G_F3;
			end
			G_F3: begin
				mu_id_q   <= blk_id(nf);
				mu_mask_q <= FM_ST | FM_SIZE | FM_LEFT;
				mu_val_q  <= mk_tag(TS_FENCE, TOT_W'(HDR_G), ns_q, '0, '0);
				uret_q    <= G_F4;
			end
			G_F4: begin
				m_node_q <= lb_q;
				m_list_q <= cls(ns_q);
				mret_q   <= G_END;
			end
			G_E1: begin
				mu_id_q   <= blk_id(nf);
				mu_mask_q <= FM_ST | FM_SIZE | FM_LEFT;
				mu_val_q  <= mk_tag(TS_FENCE, TOT_W'(HDR_G), TOT_W'(ARENA_G), '0, '0);
				uret_q    <= G_E2;
			end
			G_E2: begin
				m_node_q <= lf_q;
				m_list_q <= cls(TOT_W'(ARENA_G));
				mret_q   <= G_END;
			end
			G_END: l_q <= idx_q;
			F_1: begin
				if (rnode.st != TS_USED) begin
					status_q <= ST_DOUBLE;
				end else begin
					hs_q      <= rsize;
					lg_q      <= h_q - GRAN_W'(rleft);
					r_q       <= h_q + GRAN_W'(rsize);
					mu_id_q   <= blk_id(h_q);
					mu_mask_q <= FM_ST;
					mu_val_q  <= mk_tag(TS_FREE, '0, '0, '0, '0);
					uret_q    <= F_2;
				end
			end
			F_2: begin
				mu_id_q <= blk_id(lg_q);
				uret_q  <= F_3;
			end
			F_3: begin
				lfree_q <= rfree;
				ls_q    <= rsize;
				mu_id_q <= blk_id(r_q);
				uret_q  <= F_4;
			end
			F_4: begin
				ns_q      <= ns_calc;
				rl_node_q <= lg_q;
				rl_size_q <= ns_calc;
				rl_old_q  <= cls(ls_q);
				if (!lfree_q && !rfree) begin
					m_node_q <= h_q;
					m_list_q <= cls(hs_q);
					mret_q   <= S_FIN;
				end else if (rfree) begin
					m_node_q <= r_q;
					mret_q   <= lfree_q ? F_B1 : F_R1;
				end else begin
					mu_id_q   <= blk_id(lg_q);
					mu_mask_q <= FM_SIZE;
					mu_val_q  <= mk_tag(TS_NONE, ns_calc, '0, '0, '0);
					uret_q    <= F_L2;
				end
			end
			F_R1: begin
				mu_id_q   <= blk_id(h_q);
				mu_mask_q <= FM_SIZE;
				mu_val_q  <= mk_tag(TS_NONE, ns_q, '0, '0, '0);
				uret_q    <= F_R2;
			end
			F_R2, F_B3: begin
				mu_id_q   <= blk_id(r_q);
				mu_mask_q <= FM_ST;
				mu_val_q  <= mk_tag(TS_NONE, '0, '0, '0, '0);
				uret_q    <= (state_q == F_R2) ? F_R3 : F_B4;
			end
			F_R3: begin
				mu_id_q   <= blk_id(h_q + GRAN_W'(ns_q));
				mu_mask_q <= FM_LEFT;
				mu_val_q  <= mk_tag(TS_NONE, '0, ns_q, '0, '0);
				uret_q    <= F_R4;
			end
			F_R4: begin
				m_node_q <= h_q;
				m_list_q <= cls(ns_q);
				mret_q   <= S_FIN;
			end
			F_L2, F_B2: begin
				mu_id_q   <= blk_id(h_q);
				mu_mask_q <= FM_ST;
				mu_val_q  <= mk_tag(TS_NONE, '0, '0, '0, '0);
				uret_q    <= (state_q == F_L2) ? F_L3 : F_B3;
			end
			F_L3: begin
				mu_id_q   <= blk_id(r_q);
				mu_mask_q <= FM_LEFT;
				mu_val_q  <= mk_tag(TS_NONE, '0, ns_q, '0, '0);
				uret_q    <= RL_CHK;
			end
			F_B1: begin
				mu_id_q   <= blk_id(lg_q);
				mu_mask_q <= FM_SIZE;
				mu_val_q  <= mk_tag(TS_NONE, ns_q, '0, '0, '0);
				uret_q    <= F_B2;
			end
			F_B4: begin
				mu_id_q   <= blk_id(lg_q + GRAN_W'(ns_q));
				mu_mask_q <= FM_LEFT;
				mu_val_q  <= mk_tag(TS_NONE, '0, ns_q, '0, '0);
				uret_q    <= RL_CHK;
			end
			RL_CHK: begin
				m_node_q <= rl_node_q;
				mret_q   <= RL_PUSH;
			end
			RL_PUSH: begin
				m_node_q <= rl_node_q;
				m_list_q <= cls(rl_size_q);
				mret_q   <= S_FIN;
			end
			default: ;
		endcase
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != ST_OK |-> rsp.data_address == '0)
		else $error("failed request reported an address");

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_W'(GRANULES) && top_q >= TOP_W'(ARENA_G))
		else $error("heap top out of range");

	a_one_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_CLR |-> !(tag_we && lst_we))
		else $error("tag and list memories written together");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

endmodule
`default_nettype wire

// File: tb/segregated_free_list_allocator_tb.sv
// Self-checking testbench for segregated_free_list_allocator: a directed table, then random
// allocate/free traffic, all checked against a behavioral heap model kept in this file.
// Depends on sfa_pkg and the allocator RTL.
`default_nettype none
module segregated_free_list_allocator_tb;
	import sfa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_FREE = ~OP_ALLOC;
	localparam int unsigned ANCHOR = HEAP_BYTES;
	localparam int unsigned NO_FIT = 32'hFFFF_FFFF;
	localparam int unsigned MINBLK = 2 * HEADER_BYTES;
	localparam int N_RANDOM = 1930;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy, done;
	rsp_t rsp;

	segregated_free_list_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always #4 clk = ~clk;

	// heap model state
	int unsigned g_size [GRANULES];
	int unsigned g_left [GRANULES];
	int unsigned g_next [GRANULES];
	int unsigned g_prev [GRANULES];
	tstate_t     g_st   [GRANULES];
	int unsigned a_next [LIST_COUNT];
	int unsigned a_prev [LIST_COUNT];
	int unsigned heap_end, fence_off;

	rsp_t pending_rsp[$];
	int unsigned live_blocks[$];
	int unsigned freed_blocks[$];
	int errors = 0;
	int n_words = 0, n_alloc_ok = 0, n_oom = 0, n_free_ok = 0, n_refused = 0;

	function automatic int unsigned gi(int unsigned off);
		return (off / GRAIN) % GRANULES;
	endfunction

	function automatic int unsigned link_next(int unsigned id);
		if (id >= ANCHOR) return a_next[(id - ANCHOR) % LIST_COUNT];
		return g_next[gi(id)];
	endfunction

	function automatic int unsigned link_prev(int unsigned id);
		if (id >= ANCHOR) return a_prev[(id - ANCHOR) % LIST_COUNT];
		return g_prev[gi(id)];
	endfunction

	function automatic void set_next(int unsigned id, int unsigned v);
		if (id >= ANCHOR) a_next[(id - ANCHOR) % LIST_COUNT] = v;
		else g_next[gi(id)] = v;
	endfunction

	function automatic void set_prev(int unsigned id, int unsigned v);
		if (id >= ANCHOR) a_prev[(id - ANCHOR) % LIST_COUNT] = v;
		else g_prev[gi(id)] = v;
	endfunction

	function automatic int unsigned size_class(int unsigned sz);
		int unsigned q, i;
		q = sz / GRAIN;
		i = (q >= CLASS_BASE) ? q - CLASS_BASE : 0;
		return (i > LIST_COUNT - 1) ? LIST_COUNT - 1 : i;
	endfunction

	function automatic void unlink_block(int unsigned b);
		int unsigned n, p;
		n = link_next(b);
		p = link_prev(b);
		set_prev(n, p);
		set_next(p, n);
	endfunction

	function automatic void push_block(int unsigned b, int unsigned li);
		int unsigned s, n;
		s = ANCHOR + li;
		n = link_next(s);
		set_next(b, n);
		set_prev(b, s);
		set_prev(n, b);
		set_next(s, b);
	endfunction

	function automatic void reclass(int unsigned b, int unsigned old);
		int unsigned c;
		c = size_class(g_size[gi(b)]);
		if (c != old) begin
			unlink_block(b);
			push_block(b, c);
		end
	endfunction

	function automatic void put_tag(int unsigned off, tstate_t st, int unsigned sz,
		int unsigned lf);
		g_st[gi(off)] = st;
		g_size[gi(off)] = sz;
		g_left[gi(off)] = lf;
	endfunction

	function automatic void heap_reset();
		for (int i = 0; i < GRANULES; i++) begin
			g_size[i] = 0; g_left[i] = 0; g_next[i] = 0; g_prev[i] = 0; g_st[i] = TS_NONE;
		end
		for (int i = 0; i < LIST_COUNT; i++) begin
			a_next[i] = ANCHOR + i;
			a_prev[i] = ANCHOR + i;
		end
		put_tag(0, TS_FENCE, HEADER_BYTES, HEADER_BYTES);
		put_tag(HEADER_BYTES, TS_FREE, ARENA_BYTES - 2 * HEADER_BYTES, HEADER_BYTES);
		put_tag(ARENA_BYTES - HEADER_BYTES, TS_FENCE, HEADER_BYTES,
			ARENA_BYTES - 2 * HEADER_BYTES);
		push_block(HEADER_BYTES, size_class(ARENA_BYTES - 2 * HEADER_BYTES));
		heap_end = ARENA_BYTES;
		fence_off = ARENA_BYTES - HEADER_BYTES;
	endfunction

	function automatic int unsigned fit_search(int unsigned total);
		int unsigned b;
		for (int unsigned l = total / GRAIN - CLASS_BASE; l < LIST_COUNT - 1; l++)
			if (a_next[l] < ANCHOR) return a_next[l];
		b = a_next[LIST_COUNT - 1];
		for (int g = 0; b < ANCHOR && g <= GRANULES; g++) begin
			if (g_size[gi(b)] >= total) return b;
			b = g_next[gi(b)];
		end
		return NO_FIT;
	endfunction

	function automatic bit add_arena();
		int unsigned nf, lb, ns;
		if (heap_end + ARENA_BYTES > HEAP_BYTES) return 1'b0;
		nf = heap_end + ARENA_BYTES - HEADER_BYTES;
		lb = fence_off - g_left[gi(fence_off)];
		if (g_st[gi(lb)] == TS_FREE) begin
			// last block free: it swallows the old fencepost and the new arena
			unlink_block(lb);
			ns = g_size[gi(lb)] + ARENA_BYTES;
			g_size[gi(lb)] = ns;
			g_st[gi(fence_off)] = TS_NONE;
			put_tag(nf, TS_FENCE, HEADER_BYTES, ns);
			push_block(lb, size_class(ns));
		end else begin
			g_st[gi(fence_off)] = TS_FREE;
			g_size[gi(fence_off)] = ARENA_BYTES;
			put_tag(nf, TS_FENCE, HEADER_BYTES, ARENA_BYTES);
			push_block(fence_off, size_class(ARENA_BYTES));
		end
		heap_end += ARENA_BYTES;
		fence_off = nf;
		return 1'b1;
	endfunction

	function automatic rsp_t model_alloc(int unsigned rs);
		rsp_t r;
		int unsigned total, b, sz, old, rest, a;
		r = '0;
		if (rs == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		total = ((rs + GRAIN - 1) & ~(GRAIN - 1)) + HEADER_BYTES;
		if (total < MINBLK) total = MINBLK;
		forever begin
			b = fit_search(total);
			if (b != NO_FIT) break;
			if (!add_arena()) begin
				r.status = ST_OOM;
				return r;
			end
		end
		sz = g_size[gi(b)];
		old = size_class(sz);
		r.status = ST_OK;
		if (sz >= MINBLK + total) begin
			rest = sz - total;
			a = b + rest;
			put_tag(a, TS_USED, total, rest);
			g_left[gi(a + total)] = total;
			g_size[gi(b)] = rest;
			reclass(b, old);
			r.data_address = 16'(a + HEADER_BYTES);
			return r;
		end
		g_st[gi(b)] = TS_USED;
		unlink_block(b);
		r.data_address = 16'(b + HEADER_BYTES);
		return r;
	endfunction

	function automatic status_t model_free(int unsigned addr);
		int unsigned h, l, rt, ns, old;
		bit lf, rf;
		if (addr == 0) return ST_NULL;
		if (addr < HEADER_BYTES || addr % GRAIN != 0) return ST_DOUBLE;
		h = addr - HEADER_BYTES;
		if (h >= heap_end || g_st[gi(h)] != TS_USED) return ST_DOUBLE;
		g_st[gi(h)] = TS_FREE;
		l = h - g_left[gi(h)];
		rt = h + g_size[gi(h)];
		lf = g_st[gi(l)] == TS_FREE;
		rf = g_st[gi(rt)] == TS_FREE;
		if (!lf && !rf) begin
			push_block(h, size_class(g_size[gi(h)]));
		end else if (!lf) begin
			unlink_block(rt);
			ns = g_size[gi(h)] + g_size[gi(rt)];
			g_size[gi(h)] = ns;
			g_st[gi(rt)] = TS_NONE;
			g_left[gi(h + ns)] = ns;
			push_block(h, size_class(ns));
		end else if (!rf) begin
			old = size_class(g_size[gi(l)]);
			ns = g_size[gi(l)] + g_size[gi(h)];
			g_size[gi(l)] = ns;
			g_st[gi(h)] = TS_NONE;
			g_left[gi(rt)] = ns;
			reclass(l, old);
		end else begin
			old = size_class(g_size[gi(l)]);
			unlink_block(rt);
			ns = g_size[gi(l)] + g_size[gi(h)] + g_size[gi(rt)];
			g_size[gi(l)] = ns;
			g_st[gi(h)] = TS_NONE;
			g_st[gi(rt)] = TS_NONE;
			g_left[gi(l + ns)] = ns;
			reclass(l, old);
		end
		return ST_OK;
	endfunction

	function automatic rsp_t heap_predict(req_t w);
		rsp_t r;
		if (w.opcode == OP_ALLOC) begin
			r = model_alloc(w.request_size);
			if (r.status == ST_OK) begin
				live_blocks.push_back(r.data_address);
				n_alloc_ok++;
			end
			if (r.status == ST_OOM) n_oom++;
		end else begin
			r = '0;
			r.status = model_free(w.block_address);
			if (r.status == ST_OK) begin
				n_free_ok++;
				if (freed_blocks.size() > 64) void'(freed_blocks.pop_front());
				freed_blocks.push_back(w.block_address);
			end else begin
				n_refused++;
			end
		end
		return r;
	endfunction

	// sender: bursts of back-to-back words, random gaps between bursts
	int burst_left = 0;

	task automatic send_word(input req_t w, input bit fixed, input rsp_t fixed_rsp);
		rsp_t p;
		req <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		p = heap_predict(w);
		if (fixed && p != fixed_rsp) begin
			$error("table row disagrees with heap model: %h vs %h", fixed_rsp, p);
			errors++;
		end
		pending_rsp.push_back(fixed ? fixed_rsp : p);
		n_words++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			start <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 5))
				@(posedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$error("result word with nothing expected: %h", rsp);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.data_address !== e.data_address) begin
					$error("data_address expected %0d actual %0d", e.data_address,
						rsp.data_address);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					errors++;
				end
			end
		end
	end

	typedef struct {
		logic        op;
		int unsigned val;
		bit          use_last;  // free the newest live block
		bit          fixed;
		rsp_t        want;
	} row_t;

	function automatic rsp_t mk(int unsigned a, status_t s);
		rsp_t r;
		r.data_address = 16'(a);
		r.status = s;
		return r;
	endfunction

	row_t dir_rows[] = '{
		'{OP_ALLOC, 0,     0, 1, mk(0, ST_ZERO)},
		'{OP_FREE,  0,     0, 1, mk(0, ST_NULL)},
		'{OP_FREE,  8,     0, 1, mk(0, ST_DOUBLE)},
		'{OP_FREE,  17,    0, 1, mk(0, ST_DOUBLE)},
		'{OP_FREE,  65528, 0, 1, mk(0, ST_DOUBLE)},
		'{OP_ALLOC, 1,     0, 1, mk(4064, ST_OK)},
		'{OP_FREE,  4064,  0, 1, mk(0, ST_OK)},
		'{OP_FREE,  4064,  0, 1, mk(0, ST_DOUBLE)},
		'{OP_ALLOC, 65535, 0, 1, mk(0, ST_OOM)},
		'{OP_ALLOC, 4064,  0, 0, '0},
		'{OP_ALLOC, 8,     0, 0, '0},
		'{OP_ALLOC, 9,     0, 0, '0},
		'{OP_ALLOC, 24,    0, 0, '0},
		'{OP_FREE,  0,     1, 0, '0},
		'{OP_ALLOC, 400,   0, 0, '0},
		'{OP_ALLOC, 65520, 0, 0, '0},
		'{OP_ALLOC, 60000, 0, 0, '0},
		'{OP_FREE,  0,     1, 0, '0},
		'{OP_FREE,  0,     1, 0, '0},
		'{OP_ALLOC, 32768, 0, 0, '0},
		'{OP_FREE,  65535, 0, 1, mk(0, ST_DOUBLE)},
		'{OP_FREE,  0,     1, 0, '0}
	};

	initial begin
		req_t w;
		int k;
		heap_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			w = '0;
			w.opcode = dir_rows[i].op;
			if (dir_rows[i].op == OP_ALLOC) begin
				w.request_size = 16'(dir_rows[i].val);
			end else if (dir_rows[i].use_last && live_blocks.size() > 0) begin
				w.block_address = 16'(live_blocks.pop_back());
			end else begin
				w.block_address = 16'(dir_rows[i].val);
			end
			send_word(w, dir_rows[i].fixed, dir_rows[i].want);
		end
		for (int n = 0; n < N_RANDOM; n++) begin
			w = '0;
			w.request_size = 16'($urandom);
			w.block_address = 16'($urandom);
			k = $urandom_range(0, 99);
			if (k < 55 - (live_blocks.size() > 40 ? 20 : 0)) begin
				w.opcode = OP_ALLOC;
				k = $urandom_range(0, 99);
				if (k < 70) w.request_size = 16'($urandom_range(1, 200));
				else if (k < 92) w.request_size = 16'($urandom_range(1, 4096));
				else if (k < 94) w.request_size = 16'd0;
				// otherwise keep the full-range random size
			end else begin
				w.opcode = OP_FREE;
				k = $urandom_range(0, 99);
				if (k < 82 && live_blocks.size() > 0) begin
					k = $urandom_range(0, live_blocks.size() - 1);
					w.block_address = 16'(live_blocks[k]);
					live_blocks.delete(k);
				end else if (k < 90 && freed_blocks.size() > 0) begin
					w.block_address = 16'(freed_blocks[$urandom_range(0,
						freed_blocks.size() - 1)]);
				end else if (k < 93) begin
					w.block_address = 16'd0;
				end
			end
			send_word(w, 1'b0, '0);
		end
		start <= 1'b0;
		k = 0;
		while (pending_rsp.size() > 0 && k < 200000) begin
			@(posedge clk);
			k++;
		end
		repeat (200) @(posedge clk);
		if (pending_rsp.size() > 0) begin
			$error("%0d result words never arrived", pending_rsp.size());
			errors++;
		end
		$display("%0d words: %0d allocations, %0d out of memory, %0d frees, %0d refused frees",
			n_words, n_alloc_ok, n_oom, n_free_ok, n_refused);
		if (errors == 0)
			$display("segregated_free_list_allocator verification clean");
		else
			$display("segregated_free_list_allocator verification failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("segregated_free_list_allocator verification failed");
		$finish;
	end

endmodule
`default_nettype wire
